// ===== hw/rtl/aes_pkg.sv =====
// AES-128 package: payload structs, S-box tables, GF helpers, round-key step.
// No dependencies.
`timescale 1ns / 1ps
package aes_pkg;

    localparam int NUM_ROUNDS = 10;
    localparam int CFG_IDX_W  = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW  = 1'b1;
    localparam logic REQ_ENCRYPT = 1'b0;
    localparam logic REQ_DECRYPT = 1'b1;

    typedef struct packed {
        logic        req_type;
        logic [63:0] block_in_high;
        logic [63:0] block_in_low;
    } t_in_item;

    typedef struct packed {
        logic [63:0] block_out_high;
        logic [63:0] block_out_low;
    } t_out_item;

    // State handed from one round cell to the next
    typedef struct packed {
        logic         vld;
        logic         dec;
        logic [127:0] st;
        logic [127:0] rk;
    } t_cell_bus;

    localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};

    localparam logic [7:0] INV_SBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};

    // Round constants, index 1..10
    localparam logic [7:0] RCON [11] = '{8'h00, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10,
                                          8'h20, 8'h40, 8'h80, 8'h1b, 8'h36};

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // Byte i of a 128-bit word, byte 0 in the top bits
    function automatic logic [7:0] get_byte(input logic [127:0] w, input int i);
        return w[127-8*i -: 8];
    endfunction

    // Forward key schedule step: round key r-1 to round key r
    function automatic logic [127:0] key_fwd(input logic [127:0] k, input logic [7:0] rc);
        logic [31:0] w0, w1, w2, w3, t;
        w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
        t  = {SBOX[w3[23:16]] ^ rc, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
        w0 = w0 ^ t; w1 = w1 ^ w0; w2 = w2 ^ w1; w3 = w3 ^ w2;
        return {w0, w1, w2, w3};
    endfunction

    // Inverse key schedule step: round key r to round key r-1
    function automatic logic [127:0] key_inv(input logic [127:0] k, input logic [7:0] rc);
        logic [31:0] w0, w1, w2, w3, p3, t;
        w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
        p3 = w3 ^ w2;
        t  = {SBOX[p3[23:16]] ^ rc, SBOX[p3[15:8]], SBOX[p3[7:0]], SBOX[p3[31:24]]};
        return {w0 ^ t, w1 ^ w0, w2 ^ w1, p3};
    endfunction

endpackage

// ===== hw/rtl/aes_key_cell.sv =====
// One cell of the key-schedule row: steps a round key forward by one round.
// Depends on aes_pkg.
`timescale 1ns / 1ps
module aes_key_cell (
    input  logic         i_clk,
    input  logic [127:0] i_key,
    input  logic [7:0]   i_rcon,
    output logic [127:0] o_key
);
    logic [127:0] r_key;
    always_ff @(posedge i_clk) begin
        r_key <= aes_pkg::key_fwd(i_key, i_rcon);
    end
    assign o_key = r_key;
endmodule

// ===== hw/rtl/aes_round_cell.sv =====
// One round cell of the cipher row: encrypt or decrypt round plus key step.
// Depends on aes_pkg.
`timescale 1ns / 1ps
module aes_round_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_last,
    input  logic [7:0]          i_rcon,
    input  aes_pkg::t_cell_bus  i_bus,
    output aes_pkg::t_cell_bus  o_bus
);
    aes_pkg::t_cell_bus r_bus;
    logic [127:0] sr, sb, mc, enc, dec, isb, isr, ark, imc, rk_e, rk_d;
    logic [7:0]   a0, a1, a2, a3;

    function automatic logic [7:0] gm(input logic [7:0] a, input logic [3:0] k);
        logic [7:0] x2, x4, x8;
        x2 = aes_pkg::xtime(a);
        x4 = aes_pkg::xtime(x2);
        x8 = aes_pkg::xtime(x4);
        return (k[0] ? a : 8'h00) ^ (k[1] ? x2 : 8'h00) ^ (k[2] ? x4 : 8'h00)
             ^ (k[3] ? x8 : 8'h00);
    endfunction

    always_comb begin
        // forward: sub bytes, shift rows, mix columns
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                sb[127-8*(r+4*c) -: 8] = aes_pkg::SBOX[aes_pkg::get_byte(i_bus.st, r+4*c)];
            end
        end
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                sr[127-8*(r+4*c) -: 8] = aes_pkg::get_byte(sb, r + 4*((c+r)%4));
            end
        end
        for (int c = 0; c < 4; c++) begin
            a0 = aes_pkg::get_byte(sr, 4*c);
            a1 = aes_pkg::get_byte(sr, 4*c+1);
            a2 = aes_pkg::get_byte(sr, 4*c+2);
            a3 = aes_pkg::get_byte(sr, 4*c+3);
            mc[127-32*c -: 32] = {
                aes_pkg::xtime(a0) ^ aes_pkg::xtime(a1) ^ a1 ^ a2 ^ a3,
                a0 ^ aes_pkg::xtime(a1) ^ aes_pkg::xtime(a2) ^ a2 ^ a3,
                a0 ^ a1 ^ aes_pkg::xtime(a2) ^ aes_pkg::xtime(a3) ^ a3,
                aes_pkg::xtime(a0) ^ a0 ^ a1 ^ a2 ^ aes_pkg::xtime(a3)};
        end
        rk_e = aes_pkg::key_fwd(i_bus.rk, i_rcon);
        enc  = (i_last ? sr : mc) ^ rk_e;

        // inverse: shift rows, sub bytes, add key, mix columns
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                isr[127-8*(r+4*((c+r)%4)) -: 8] = aes_pkg::get_byte(i_bus.st, r+4*c);
            end
        end
        for (int i = 0; i < 16; i++) begin
            isb[127-8*i -: 8] = aes_pkg::INV_SBOX[aes_pkg::get_byte(isr, i)];
        end
        // key for this round is the incoming one stepped back
        rk_d = aes_pkg::key_inv(i_bus.rk, i_rcon);
        ark  = isb ^ rk_d;
        for (int c = 0; c < 4; c++) begin
            a0 = aes_pkg::get_byte(ark, 4*c);
            a1 = aes_pkg::get_byte(ark, 4*c+1);
            a2 = aes_pkg::get_byte(ark, 4*c+2);
            a3 = aes_pkg::get_byte(ark, 4*c+3);
            // inverse mix: coefficients 0e, 0b, 0d, 09 rotated per row
            imc[127-32*c -: 32] = {
                gm(a0,4'he) ^ gm(a1,4'hb) ^ gm(a2,4'hd) ^ gm(a3,4'h9),
                gm(a0,4'h9) ^ gm(a1,4'he) ^ gm(a2,4'hb) ^ gm(a3,4'hd),
                gm(a0,4'hd) ^ gm(a1,4'h9) ^ gm(a2,4'he) ^ gm(a3,4'hb),
                gm(a0,4'hb) ^ gm(a1,4'hd) ^ gm(a2,4'h9) ^ gm(a3,4'he)};
        end
        dec = i_last ? ark : imc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bus.vld <= 1'b0;
        end else if (i_en) begin
            r_bus.vld <= i_bus.vld;
        end
        if (i_en) begin
            r_bus.dec <= i_bus.dec;
            r_bus.st  <= i_bus.dec ? dec : enc;
            r_bus.rk  <= i_bus.dec ? rk_d : rk_e;
        end
    end
    assign o_bus = r_bus;
endmodule

// ===== hw/rtl/aes128_block_cipher.sv =====
// AES-128 encrypt/decrypt top level: key registers, key expansion, round row.
// Depends on aes_pkg, aes_key_cell, aes_round_cell.
// Pipeline: load stage, then 10 round cells; together they hold up to 11 blocks.
// Throughput: one block per cycle, except while the output is stalled or the key row settles.
// Key expansion: a 10-cell key row recomputes the last round key after a write;
// o_ready stays low after reset and after every key write until the settle counter is zero.
// Reset: synchronous active low; clears key registers and all valid bits.
`timescale 1ns / 1ps
module aes128_block_cipher (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  aes_pkg::t_in_item  i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output aes_pkg::t_out_item o_data,
    input  logic               i_cfg_we,
    input  logic [aes_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [63:0]        i_cfg_data
);
    localparam int NR = aes_pkg::NUM_ROUNDS;

    logic [63:0]  r_key_high, r_key_low;
    logic [127:0] key0;
    logic [127:0] kchain [NR+1];
    aes_pkg::t_cell_bus bus [NR+1];
    aes_pkg::t_cell_bus r_load;
    logic         en;
    logic [3:0]   r_settle;
    logic         in_ok;

    // Key registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high <= '0;
            r_key_low  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                aes_pkg::CFG_KEY_HIGH: r_key_high <= i_cfg_data;
                aes_pkg::CFG_KEY_LOW:  r_key_low  <= i_cfg_data;
                default: ;
            endcase
        end
    end
    assign key0 = {r_key_high, r_key_low};

    // Key row: last round key for decryption. The user must change config only while idle;
    // the block does not enforce this. Input is held off until the row has settled on the new key.
    assign kchain[0] = key0;
    for (genvar k = 0; k < NR; k++) begin : g_key
        aes_key_cell u_kc (
            .i_clk  (i_clk),
            .i_key  (kchain[k]),
            .i_rcon (aes_pkg::RCON[k+1]),
            .o_key  (kchain[k+1])
        );
    end

    // Settle counter: the load stage may sample kchain[NR] once it is zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we) begin
            r_settle <= 4'(NR);
        end else if (r_settle != 4'd0) begin
            r_settle <= r_settle - 4'd1;
        end
    end
    assign in_ok = (r_settle == 4'd0);

    // Whole row advances together; stall only when output is held
    assign en      = !o_valid || i_ready;
    assign o_ready = en && in_ok;

    // Load stage: whitening with round key 0 (enc) or round key 10 (dec)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load.vld <= 1'b0;
        end else if (en) begin
            r_load.vld <= i_valid && in_ok;
        end
        if (en) begin
            r_load.dec <= i_data.req_type;
            r_load.rk  <= i_data.req_type ? kchain[NR] : key0;
            r_load.st  <= {i_data.block_in_high, i_data.block_in_low}
                        ^ (i_data.req_type ? kchain[NR] : key0);
        end
    end
    assign bus[0] = r_load;

    // Encrypt cell i runs round i+1; decrypt cell i runs round NR-1-i
    for (genvar i = 0; i < NR; i++) begin : g_round
        logic [7:0] rc;
        assign rc = bus[i].dec ? aes_pkg::RCON[NR-i] : aes_pkg::RCON[i+1];
        aes_round_cell u_rc (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_last  (i == NR-1),
            .i_rcon  (rc),
            .i_bus   (bus[i]),
            .o_bus   (bus[i+1])
        );
    end

    assign o_valid = bus[NR].vld;
    assign o_data  = {bus[NR].st[127:64], bus[NR].st[63:0]};

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("result changed while stalled");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid && in_ok |-> o_ready)
        else $error("not ready with empty output");
    a_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready && !bus[NR-1].vld |=> !o_valid)
        else $error("result without source");
endmodule
